### sv/stream_slot_allocator_core_assert.svh
// Assertion macros for the slot allocator.
// Used by the allocation core; no other dependencies.
`ifndef STREAM_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define STREAM_SLOT_ALLOCATOR_CORE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define SSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slot allocator check failed");

// Check a condition in the cycle after its trigger.
`define SSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slot allocator check failed");

`endif

### sv/ssa_pkg.sv
// Types and constants shared by the slot allocator modules.
// No dependencies.
package ssa_pkg;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int SNAP_W = 32;
	localparam int OFS_W  = 21;

	localparam logic [15:0] SLOT_SIZE_RST  = 16'd256;
	localparam logic [5:0]  SLOT_COUNT_RST = 6'd32;

	typedef enum logic {
		REG_SLOT_SIZE  = 1'b0,
		REG_SLOT_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_NO_SLOT   = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0] slot_size;
		logic [5:0]  slot_count;
	} cfg_t;

	typedef struct packed {
		logic [15:0]       data_length;
		logic [SNAP_W-1:0] flags_snapshot;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [4:0]       slot_index;
		logic [OFS_W-1:0] data_offset;
		logic [OFS_W-1:0] meta_offset;
		logic [15:0]      length_out;
		logic             flag_value;
		logic [31:0]      sequence_number;
	} rsp_t;

endpackage

### sv/ssa_cfg_regs.sv
// APB configuration registers: slot size and slot count.
// Depends on ssa_pkg.
module ssa_cfg_regs import ssa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_size  <= SLOT_SIZE_RST;
			cfg_q.slot_count <= SLOT_COUNT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SLOT_SIZE:  cfg_q.slot_size  <= pwdata[15:0];
				REG_SLOT_COUNT: cfg_q.slot_count <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SLOT_SIZE:  prdata = DATA_W'(cfg_q.slot_size);
			REG_SLOT_COUNT: prdata = DATA_W'(cfg_q.slot_count);
			default:        prdata = '0;
		endcase
	end

endmodule

### sv/ssa_alloc.sv
// Allocation core: ownership flags, free mask, sequence counter and the
// combinational reclaim / pick / offset logic. Depends on ssa_pkg.
module ssa_alloc import ssa_pkg::*; #(
	parameter int MAX_SLOTS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic fire,
	input  req_t req,
	output rsp_t rsp
);

	`include "stream_slot_allocator_core_assert.svh"

	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	logic [MAX_SLOTS-1:0] flags_q, free_q;
	logic [31:0]          ctr_q;

	logic [6:0]           cnt;
	logic [MAX_SLOTS-1:0] act, snap_ext, diff, avail0, avail, onehot;
	logic [MAX_SLOTS-1:0] flags_cur, free_cur;
	logic                 too_large, need_rec, found;
	logic [SW-1:0]        slot;
	logic [SW+4:0]        slot_x;
	logic [SW+20:0]       data_prod;
	logic [23:0]          meta_sum;

	assign cnt = ({1'b0, cfg.slot_count} > 7'(MAX_SLOTS)) ? 7'(MAX_SLOTS)
		: {1'b0, cfg.slot_count};

	for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_lane
		assign act[g] = 7'(g) < cnt;
		if (g < SNAP_W) begin : g_snap
			assign snap_ext[g] = req.flags_snapshot[g];
		end else begin : g_nosnap
			assign snap_ext[g] = 1'b0;
		end
	end

	assign too_large = req.data_length > cfg.slot_size;
	assign avail0    = free_q & act;
	assign need_rec  = (avail0 == '0);
	// reclaim only slots whose consumer flag has toggled
	assign diff      = (snap_ext ^ flags_q) & act;
	assign flags_cur = need_rec ? (flags_q ^ diff) : flags_q;
	assign free_cur  = need_rec ? (free_q | diff) : free_q;
	assign avail     = free_cur & act;
	assign found     = |avail;
	assign onehot    = avail & (~avail + MAX_SLOTS'(1));

	always_comb begin
		slot = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			if (onehot[i])
				slot = slot | SW'(i);
		end
	end

	assign slot_x    = (SW+5)'(slot);
	assign data_prod = (SW+21)'(slot) * (SW+21)'(cfg.slot_size);
	assign meta_sum  = 24'(cnt) * 24'(cfg.slot_size) + 24'(slot);

	always_comb begin
		rsp = '0;
		if (too_large) begin
			rsp.status = ST_TOO_LARGE;
		end else if (!found) begin
			rsp.status = ST_NO_SLOT;
		end else begin
			rsp.status          = ST_OK;
			rsp.slot_index      = slot_x[4:0];
			rsp.data_offset     = data_prod[OFS_W-1:0];
			rsp.meta_offset     = meta_sum[OFS_W-1:0];
			rsp.length_out      = req.data_length;
			rsp.flag_value      = flags_cur[slot];
			rsp.sequence_number = ctr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			free_q  <= '1;
			ctr_q   <= '0;
		end else if (fire && !too_large) begin
			flags_q <= flags_cur;
			if (found) begin
				free_q <= free_cur & ~onehot;
				ctr_q  <= ctr_q + 32'd1;
			end else begin
				free_q <= free_cur;
			end
		end
	end

	`SSA_ASSERT_NEXT(a_seq_adv, clk, arst_n, fire && rsp.status == ST_OK,
		ctr_q == $past(ctr_q) + 32'd1)
	`SSA_ASSERT_NEXT(a_idle_hold, clk, arst_n, !fire,
		$stable(flags_q) && $stable(free_q) && $stable(ctr_q))
	`SSA_ASSERT_NOW(a_pick_onehot, clk, arst_n, found, $onehot(onehot) && ((onehot & act) == onehot))
	`SSA_ASSERT_NEXT(a_too_large_nop, clk, arst_n, fire && too_large,
		$stable(flags_q) && $stable(free_q))

endmodule

### sv/stream_slot_allocator_core.sv
// Slot allocator top level: request register, allocation core, result register.
// Requests wait in the request register, results in the result register.
// Throughput: one request per cycle unless a result stalls; the reclaim, pick and
// offset logic of the core sits in the single stage between the two registers.
// Reset (arst_n low): all slots free, flags and sequence number zero,
// slot size 256, slot count 32, no request or result held.
module stream_slot_allocator_core import ssa_pkg::*; #(
	parameter int MAX_SLOTS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp
);

	cfg_t cfg;
	req_t req_s1;
	logic req_valid_s1;
	rsp_t rsp_c, rsp_q;
	logic rsp_valid_q;
	logic advance, accept;

	ssa_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	ssa_alloc #(.MAX_SLOTS(MAX_SLOTS)) u_alloc (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.fire  (advance),
		.req   (req_s1),
		.rsp   (rsp_c)
	);

	// advance the held request when the result register is free or draining
	assign advance   = req_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = req_valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (accept) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= rsp_c;
	end

endmodule

### tb/stream_slot_allocator_core_checker.sv
// Scoreboard for the slot allocator: tracks register writes, predicts each grant and
// compares the results field by field. Depends on ssa_pkg only.
module stream_slot_allocator_core_checker import ssa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	input  logic              pready,
	input  logic              req_valid,
	input  logic              req_stall,
	input  req_t              req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  rsp_t              rsp,
	output int                outstanding,
	output int                mismatches,
	output int                n_granted,
	output int                n_too_large,
	output int                n_no_slot
);

	localparam int SLOTS = 32;

	logic [15:0]      size_reg;
	logic [5:0]       count_reg;
	logic [SLOTS-1:0] owner_flags;
	logic [SLOTS-1:0] free_slots;
	logic [31:0]      grant_seq;
	rsp_t             expected_grants[$];
	rsp_t             want;

	initial begin
		outstanding = 0;
		mismatches  = 0;
		n_granted   = 0;
		n_too_large = 0;
		n_no_slot   = 0;
	end

	function automatic rsp_t allocate_slot(input req_t r);
		rsp_t             res;
		int               active;
		int               slot;
		logic [SLOTS-1:0] act_mask;
		logic [SLOTS-1:0] avail;
		logic [SLOTS-1:0] diff;
		logic [63:0]      ofs;
		res    = '0;
		active = (count_reg > SLOTS) ? SLOTS : int'(count_reg);
		act_mask = (active >= SLOTS) ? '1 : ((SLOTS'(1) << active) - SLOTS'(1));
		if (r.data_length > size_reg) begin
			res.status = ST_TOO_LARGE;
			return res;
		end
		avail = free_slots & act_mask;
		// reclaim every active slot whose consumer flag has toggled
		if (avail == '0) begin
			diff        = (r.flags_snapshot ^ owner_flags) & act_mask;
			owner_flags = (owner_flags & ~diff) | (r.flags_snapshot & diff);
			free_slots  = free_slots | diff;
			avail       = free_slots & act_mask;
		end
		if (avail == '0) begin
			res.status = ST_NO_SLOT;
			return res;
		end
		slot = 0;
		while (!avail[slot])
			slot++;
		free_slots[slot] = 1'b0;
		res.status          = ST_OK;
		res.slot_index      = slot[4:0];
		ofs                 = 64'(slot) * 64'(size_reg);
		res.data_offset     = ofs[OFS_W-1:0];
		ofs                 = 64'(active) * 64'(size_reg) + 64'(slot);
		res.meta_offset     = ofs[OFS_W-1:0];
		res.length_out      = r.data_length;
		res.flag_value      = owner_flags[slot];
		res.sequence_number = grant_seq;
		grant_seq           = grant_seq + 32'd1;
		return res;
	endfunction

	task automatic check_field(input string name, input longint unsigned exp_v,
			input longint unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg    = SLOT_SIZE_RST;
			count_reg   = SLOT_COUNT_RST;
			owner_flags = '0;
			free_slots  = '1;
			grant_seq   = '0;
			expected_grants.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_SLOT_SIZE:  size_reg  = pwdata[15:0];
					REG_SLOT_COUNT: count_reg = pwdata[5:0];
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_grants.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = expected_grants.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("slot_index", want.slot_index, rsp.slot_index);
					check_field("data_offset", want.data_offset, rsp.data_offset);
					check_field("meta_offset", want.meta_offset, rsp.meta_offset);
					check_field("length_out", want.length_out, rsp.length_out);
					check_field("flag_value", want.flag_value, rsp.flag_value);
					check_field("sequence_number", want.sequence_number,
						rsp.sequence_number);
					case (want.status)
						ST_OK:        n_granted++;
						ST_TOO_LARGE: n_too_large++;
						default:      n_no_slot++;
					endcase
				end
			end
			if (req_valid && !req_stall)
				expected_grants.push_back(allocate_slot(req));
			outstanding <= expected_grants.size();
		end
	end

endmodule

### tb/stream_slot_allocator_core_tb.sv
// Top of the slot allocator testbench: clock, reset, register writes and request stimulus.
// Depends on ssa_pkg, stream_slot_allocator_core and stream_slot_allocator_core_checker.
module stream_slot_allocator_core_tb;
	import ssa_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int N_PHASES    = 8;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [DATA_W-1:0] pwdata  = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp;

	int outstanding;
	int mismatches;
	int n_granted;
	int n_too_large;
	int n_no_slot;

	int          quiet      = 0;
	int          idle_pct   = 0;
	int          stall_pct  = 0;
	int          sent       = 0;
	int          n_settings = 0;
	logic [15:0] cur_size   = SLOT_SIZE_RST;
	logic [5:0]  cur_count  = SLOT_COUNT_RST;
	logic [31:0] consumer_flags = '0;

	logic [15:0] size_plan  [N_PHASES] = '{16'd256, 16'd1, 16'd40, 16'hFFFF,
		16'd0, 16'd1000, 16'd12, 16'hFFFF};
	logic [5:0]  count_plan [N_PHASES] = '{6'd32, 6'd1, 6'd4, 6'd32,
		6'd3, 6'd63, 6'd0, 6'd7};

	stream_slot_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	stream_slot_allocator_core_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.outstanding (outstanding),
		.mismatches  (mismatches),
		.n_granted   (n_granted),
		.n_too_large (n_too_large),
		.n_no_slot   (n_no_slot)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("[stream_slot_allocator_core] ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic push_request(input logic [15:0] len, input logic [31:0] snap);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= '{data_length: len, flags_snapshot: snap};
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	// drop valid and hold until every grant is back
	task automatic settle();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// upper data bits are junk; only the register width counts
	task automatic configure(input logic [15:0] size, input logic [5:0] count);
		write_reg(REG_SLOT_SIZE, ($urandom() & 32'hFFFF_0000) | 32'(size));
		// let the bus go idle before the next setup phase
		@(posedge clk);
		write_reg(REG_SLOT_COUNT, ($urandom() & 32'hFFFF_FFC0) | 32'(count));
		cur_size  = size;
		cur_count = count;
		n_settings++;
	endtask

	task automatic random_request();
		logic [15:0] len;
		logic [31:0] snap;
		int          active;
		active = (cur_count > 32) ? 32 : int'(cur_count);
		if ($urandom_range(0, 9) == 0) begin
			len  = 16'($urandom_range(0, 65535));
			snap = $urandom();
		end else begin
			// consumer releases a slot now and then
			if (active > 0 && $urandom_range(0, 99) < 45)
				consumer_flags[$urandom_range(0, active - 1)] ^= 1'b1;
			if ($urandom_range(0, 19) == 0)
				consumer_flags[$urandom_range((active == 32) ? 0 : active, 31)] ^= 1'b1;
			if (cur_size != 16'hFFFF && $urandom_range(0, 11) == 0)
				len = 16'($urandom_range(int'(cur_size) + 1, 65535));
			else
				len = 16'($urandom_range(0, int'(cur_size)));
			snap = consumer_flags;
		end
		push_request(len, snap);
	endtask

	initial begin
		int n_items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: fits, exact fit, one over, largest length
		push_request(16'd0, 32'd0);
		push_request(16'd256, 32'hFFFF_FFFF);
		push_request(16'd257, 32'd0);
		push_request(16'hFFFF, 32'd0);
		settle();
		// three slots, two already taken: exhaust, reclaim, ignore high snapshot bits
		configure(16'd16, 6'd3);
		push_request(16'd16, 32'd0);
		push_request(16'd0, 32'd0);
		push_request(16'd1, 32'd3);
		push_request(16'd16, 32'd3);
		push_request(16'd2, 32'd3);
		push_request(16'd3, 32'd7);
		push_request(16'd17, 32'hFFFF_FFF8);
		push_request(16'd5, 32'hFFFF_FFF8);
		settle();
		// no active slot
		configure(16'd16, 6'd0);
		push_request(16'd0, 32'hFFFF_FFFF);
		push_request(16'd100, 32'd0);
		settle();
		// count saturates, zero slot size
		configure(16'd0, 6'd63);
		push_request(16'd0, 32'd0);
		push_request(16'd1, 32'd0);
		push_request(16'hFFFF, 32'hFFFF_FFFF);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			settle();
			configure(size_plan[ph], count_plan[ph]);
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 60; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 60; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			n_items = (count_plan[ph] == 0) ? 20 : 90;
			for (int i = 0; i < n_items; i++) begin
				if (ph == 2 && i == n_items / 2)
					settle();
				random_request();
			end
		end
		settle();

		$display("Sent %0d requests under %0d register settings with varied idling.",
			sent, n_settings);
		$display("Results: %0d granted, %0d too large, %0d with no free slot.",
			n_granted, n_too_large, n_no_slot);
		if (mismatches == 0)
			$display("[stream_slot_allocator_core] OK");
		else
			$display("[stream_slot_allocator_core] ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/ssa_pkg.sv
sv/ssa_cfg_regs.sv
sv/ssa_alloc.sv
sv/stream_slot_allocator_core.sv
tb/stream_slot_allocator_core_checker.sv
tb/stream_slot_allocator_core_tb.sv
